/* sv/wsc_pkg.sv */
// Shared constants and types for the window slope charge detector.
`default_nettype none

package wsc_pkg;

  // Field widths fixed by the sample and register formats.
  localparam int SAMPLE_W       = 16;
  localparam int THR_W          = 16;
  localparam int CFG_IDX_W      = 1;
  localparam int WINDOW_LEN_DEF = 10;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_THR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_THR = 1'd1;

  // Sequencer controls broadcast to every cell of the window.
  typedef struct packed {
    logic shift;   // move the window one place toward the oldest end
    logic launch;  // start a fold record at the oldest cell
  } wsc_ctl_t;

  // Outcome of the slope and range tests for one window.
  typedef struct packed {
    logic                slope_ok;
    logic                range_ok;
    logic [SAMPLE_W-1:0] span;
  } wsc_verdict_t;

endpackage

`default_nettype wire

/* sv/wsc_sample_if.sv */
// Input channel carrying one cell-voltage sample per beat.
`default_nettype none

interface wsc_sample_if import wsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] cell_voltage;

  modport source (output valid, output cell_voltage, input ready);
  modport sink   (input valid, input cell_voltage, output ready);
endinterface

`default_nettype wire

/* sv/wsc_result_if.sv */
// Output channel carrying one detection result per beat.
`default_nettype none

interface wsc_result_if import wsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                charging;
  logic                window_full;
  logic [SAMPLE_W-1:0] voltage_range;

  modport source (output valid, output charging, output window_full,
                  output voltage_range, input ready);
  modport sink   (input valid, input charging, input window_full,
                  input voltage_range, output ready);
endinterface

`default_nettype wire

/* sv/wsc_cfg_if.sv */
// Configuration write channel: register index and write data per beat.
`default_nettype none

interface wsc_cfg_if import wsc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THR_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/wsc_cell.sv */
// One window cell: holds a sample and folds it into the passing record.
`default_nettype none

module wsc_cell import wsc_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF,
  parameter int IDX        = 0
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wsc_ctl_t            ctl,
  input  wire logic [SAMPLE_W-1:0] shift_in,
  output      logic [SAMPLE_W-1:0] sample_q,
  input  wire logic                tok_in,
  input  wire logic [SAMPLE_W-1:0] lo_in,
  input  wire logic [SAMPLE_W-1:0] hi_in,
  input  wire logic [SAMPLE_W+$clog2(WINDOW_LEN+1)-1:0] sum_y_in,
  input  wire logic [SAMPLE_W+$clog2(WINDOW_LEN*(WINDOW_LEN-1)/2+1)-1:0] sum_xy_in,
  output      logic                tok,
  output      logic [SAMPLE_W-1:0] lo,
  output      logic [SAMPLE_W-1:0] hi,
  output      logic [SAMPLE_W+$clog2(WINDOW_LEN+1)-1:0] sum_y,
  output      logic [SAMPLE_W+$clog2(WINDOW_LEN*(WINDOW_LEN-1)/2+1)-1:0] sum_xy
);

  localparam int SUMX    = WINDOW_LEN * (WINDOW_LEN - 1) / 2;
  localparam int SUMY_W  = SAMPLE_W + $clog2(WINDOW_LEN + 1);
  localparam int SUMXY_W = SAMPLE_W + $clog2(SUMX + 1);

  logic               fire;
  logic [SUMXY_W-1:0] weighted;

  // The oldest cell opens a new record; the others pass the neighbor's on.
  assign fire     = (IDX == 0) ? ctl.launch : tok_in;
  assign weighted = SUMXY_W'(sample_q) * SUMXY_W'(IDX);

  // Sample register, loaded from the newer neighbor on a window shift.
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      sample_q <= shift_in;
    end
  end

  // Record stage: fold this cell's sample into min, max and both sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
    end else begin
      tok <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      lo     <= (sample_q < lo_in) ? sample_q : lo_in;
      hi     <= (sample_q > hi_in) ? sample_q : hi_in;
      sum_y  <= sum_y_in + SUMY_W'(sample_q);
      sum_xy <= sum_xy_in + weighted;
    end
  end

endmodule

`default_nettype wire

/* sv/wsc_decide.sv */
// Slope and range tests on the finished window record.
`default_nettype none

module wsc_decide import wsc_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                clk,
  input  wire logic                load,
  input  wire logic [SAMPLE_W-1:0] lo,
  input  wire logic [SAMPLE_W-1:0] hi,
  input  wire logic [SAMPLE_W+$clog2(WINDOW_LEN+1)-1:0] sum_y,
  input  wire logic [SAMPLE_W+$clog2(WINDOW_LEN*(WINDOW_LEN-1)/2+1)-1:0] sum_xy,
  input  wire logic [THR_W-1:0]    slope_thr,
  input  wire logic [THR_W-1:0]    range_thr,
  output      wsc_verdict_t        verdict
);

  localparam int SUMX    = WINDOW_LEN * (WINDOW_LEN - 1) / 2;
  localparam int DEN     = WINDOW_LEN * WINDOW_LEN * (WINDOW_LEN * WINDOW_LEN - 1) / 12;
  localparam int SUMY_W  = SAMPLE_W + $clog2(WINDOW_LEN + 1);
  localparam int SUMXY_W = SAMPLE_W + $clog2(SUMX + 1);
  localparam int P1_W    = SUMXY_W + $clog2(WINDOW_LEN + 1);
  localparam int P2_W    = SUMY_W + $clog2(SUMX + 1);
  localparam int P3_W    = THR_W + $clog2(DEN + 1);
  localparam int P_W     = (P1_W > P2_W) ? P1_W : P2_W;
  localparam int NUM_W   = P_W + 1;
  localparam int LHS_W   = NUM_W + 4;
  localparam int CMP_W   = ((LHS_W > P3_W + 1) ? LHS_W : P3_W + 1) + 1;

  logic [P1_W-1:0]         p1;
  logic [P2_W-1:0]         p2;
  logic [P3_W-1:0]         p3;
  logic [SAMPLE_W-1:0]     span;
  logic signed [NUM_W-1:0] num;
  logic signed [CMP_W-1:0] lhs;
  logic signed [CMP_W-1:0] rhs;

  // Product stage: N*sumXY, sumX*sumY and threshold times the denominator.
  always_ff @(posedge clk) begin
    if (load) begin
      p1   <= P1_W'(sum_xy) * P1_W'(WINDOW_LEN);
      p2   <= P2_W'(sum_y) * P2_W'(SUMX);
      p3   <= P3_W'(slope_thr) * P3_W'(DEN);
      span <= hi - lo;
    end
  end

  // Compare 16 times the slope numerator against the scaled threshold, and the span against the range threshold.
  always_comb begin
    num = $signed(NUM_W'(p1)) - $signed(NUM_W'(p2));
    lhs = CMP_W'($signed({num, 4'b0000}));
    rhs = $signed({1'b0, (CMP_W-1)'(p3)});
    verdict.slope_ok = (lhs > rhs);
    verdict.range_ok = (span > range_thr);
    verdict.span     = span;
  end

endmodule

`default_nettype wire

/* sv/window_slope_charge_detector.sv */
// Top level: sample window of cells, sequencer, tests and result register.
// A new sample is taken only once the previous sample's result has been registered;
// the fold record walks the cell chain one cell per cycle, then one product stage
// and one compare stage follow before the result register.
// A waiting result does not block the next sample until that sample's result is due.
// Reset clears the fill count, sequencer and result valid and loads the thresholds
// with 205 and 64; window samples stay unknown until shifted in.
`default_nettype none

module window_slope_charge_detector import wsc_pkg::*; #(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  wsc_sample_if.sink   sample,
  wsc_result_if.source result,
  wsc_cfg_if.sink      cfg
);

  localparam int SUMX    = WINDOW_LEN * (WINDOW_LEN - 1) / 2;
  localparam int SUMY_W  = SAMPLE_W + $clog2(WINDOW_LEN + 1);
  localparam int SUMXY_W = SAMPLE_W + $clog2(SUMX + 1);
  localparam int FC_W    = $clog2(WINDOW_LEN + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_CMP   = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic               launch;
  logic [FC_W-1:0]    fill_count;
  logic               item_full;
  logic [THR_W-1:0]   slope_thr;
  logic [THR_W-1:0]   range_thr;
  logic               in_fire;
  logic               out_free;
  logic               out_valid;
  logic               out_charging;
  logic               out_full;
  logic [SAMPLE_W-1:0] out_range;
  wsc_ctl_t           ctl;
  wsc_verdict_t       verdict;

  // Per-cell chain signals, each read at its own fixed neighbor.
  logic [SAMPLE_W-1:0] smp    [WINDOW_LEN];
  logic                tok_c  [WINDOW_LEN];
  logic [SAMPLE_W-1:0] lo_c   [WINDOW_LEN];
  logic [SAMPLE_W-1:0] hi_c   [WINDOW_LEN];
  logic [SUMY_W-1:0]   sy_c   [WINDOW_LEN];
  logic [SUMXY_W-1:0]  sxy_c  [WINDOW_LEN];

  assign in_fire      = sample.valid && sample.ready;
  assign sample.ready = (state == ST_IDLE);
  assign out_free     = !out_valid || result.ready;
  assign ctl.shift    = in_fire;
  assign ctl.launch   = launch;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_thr <= THR_W'(205);
      range_thr <= THR_W'(64);
    end else if (cfg.valid) begin
      if (cfg.index == REG_SLOPE_THR) begin
        slope_thr <= cfg.data;
      end else if (cfg.index == REG_RANGE_THR) begin
        range_thr <= cfg.data;
      end
    end
  end

  // Cell chain: cell 0 holds the oldest sample, the last cell the newest.
  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    logic [SAMPLE_W-1:0] shift_in;
    logic                tok_in;
    logic [SAMPLE_W-1:0] lo_in;
    logic [SAMPLE_W-1:0] hi_in;
    logic [SUMY_W-1:0]   sy_in;
    logic [SUMXY_W-1:0]  sxy_in;

    if (i == WINDOW_LEN - 1) begin : g_tail
      assign shift_in = sample.cell_voltage;
    end else begin : g_mid
      assign shift_in = smp[i+1];
    end

    if (i == 0) begin : g_head
      assign tok_in = 1'b0;
      assign lo_in  = '1;
      assign hi_in  = '0;
      assign sy_in  = '0;
      assign sxy_in = '0;
    end else begin : g_link
      assign tok_in = tok_c[i-1];
      assign lo_in  = lo_c[i-1];
      assign hi_in  = hi_c[i-1];
      assign sy_in  = sy_c[i-1];
      assign sxy_in = sxy_c[i-1];
    end

    wsc_cell #(
      .WINDOW_LEN (WINDOW_LEN),
      .IDX        (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .shift_in  (shift_in),
      .sample_q  (smp[i]),
      .tok_in    (tok_in),
      .lo_in     (lo_in),
      .hi_in     (hi_in),
      .sum_y_in  (sy_in),
      .sum_xy_in (sxy_in),
      .tok       (tok_c[i]),
      .lo        (lo_c[i]),
      .hi        (hi_c[i]),
      .sum_y     (sy_c[i]),
      .sum_xy    (sxy_c[i])
    );
  end

  // Slope and range tests on the record leaving the newest cell.
  wsc_decide #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_decide (
    .clk       (clk),
    .load      (tok_c[WINDOW_LEN-1]),
    .lo        (lo_c[WINDOW_LEN-1]),
    .hi        (hi_c[WINDOW_LEN-1]),
    .sum_y     (sy_c[WINDOW_LEN-1]),
    .sum_xy    (sxy_c[WINDOW_LEN-1]),
    .slope_thr (slope_thr),
    .range_thr (range_thr),
    .verdict   (verdict)
  );

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (tok_c[WINDOW_LEN-1]) state_next = ST_CMP;
      end
      ST_CMP: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer state, record launch and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      launch     <= 1'b0;
      fill_count <= '0;
    end else begin
      state  <= state_next;
      launch <= in_fire;
      if (in_fire && (fill_count != FC_W'(WINDOW_LEN))) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  // Whether the window is full once this beat's sample is in.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_full <= (fill_count >= FC_W'(WINDOW_LEN - 1));
    end
  end

  // Result register; holds the beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_CMP) && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_CMP) && out_free) begin
      out_charging <= item_full && verdict.slope_ok && verdict.range_ok;
      out_full     <= item_full;
      out_range    <= item_full ? verdict.span : '0;
    end
  end

  assign result.valid         = out_valid;
  assign result.charging      = out_charging;
  assign result.window_full   = out_full;
  assign result.voltage_range = out_range;

endmodule

`default_nettype wire

/* sv/wsc_checker.sv */
// Port-level assertions for the charge detector, bound to the top level.
`default_nettype none

module wsc_checker import wsc_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic                charging,
  input wire logic                window_full,
  input wire logic [SAMPLE_W-1:0] voltage_range
);

  // No result is offered in the cycle after reset.
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result beat stays offered.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  // Charging is only reported for a full window.
  a_charging_needs_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && charging) |-> window_full)
    else $error("charging flagged with a partial window");

  // The range reads zero until the window is full.
  a_range_zero_partial: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !window_full) |-> (voltage_range == '0))
    else $error("nonzero range with a partial window");

  // One sample at a time: input closes right after a sample beat.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second sample taken while one is in flight");

endmodule

bind window_slope_charge_detector wsc_checker u_wsc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (sample.valid),
  .in_ready      (sample.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .charging      (result.charging),
  .window_full   (result.window_full),
  .voltage_range (result.voltage_range)
);

`default_nettype wire
